>>> hw/rtl/lrma_pkg.sv
// ----------------------------------------------------------------------------
// Log-return mass accumulator package
// Shared types, constants and the logarithm table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lrma_pkg;

  localparam int unsigned LogTableBits = 10;
  localparam int unsigned TabSize      = (1 << LogTableBits) + 1;
  localparam int unsigned TabIdxW      = LogTableBits + 1;
  localparam int unsigned RemBits      = 31 - LogTableBits;
  localparam logic [31:0] Ln2Q32       = 32'hB17217F8;
  localparam logic [31:0] Sat32        = 32'hFFFF_FFFF;
  localparam logic [15:0] Sat16        = 16'hFFFF;
  localparam logic [16:0] DecayOne     = 17'h10000;

  localparam logic [2:0] RegCritical = 3'd0;
  localparam logic [2:0] RegForm     = 3'd1;
  localparam logic [2:0] RegCollapse = 3'd2;
  localparam logic [2:0] RegDecay    = 3'd3;
  localparam logic [2:0] RegRunReq   = 3'd4;

  localparam logic signed [1:0] DirUp   = 2'sb01;
  localparam logic signed [1:0] DirDown = 2'sb11;
  localparam logic signed [1:0] DirNone = 2'sb00;

  typedef logic [24:0] log_tab_t [TabSize];

  typedef struct packed {
    logic [31:0] critical_level;
    logic [31:0] form_threshold;
    logic [31:0] collapse_threshold;
    logic [16:0] decay_factor;
    logic [15:0] run_required;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic norm;
    logic sel_last;
    logic rom_rd;
    logic interp;
    logic beta;
    logic decay;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } status_t;

  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] z;
    logic [24:0] res;
    for (int i = 0; i < TabSize - 1; i++) begin
      z   = 64'((1 << LogTableBits) + i) << (30 - LogTableBits);
      res = '0;
      for (int k = 1; k <= 24; k++) begin
        z = (z * z) >> 30;
        if (z >= (64'd2 << 30)) begin
          z = z >> 1;
          res = res | (25'd1 << (24 - k));
        end
      end
      tab[i] = res;
    end
    tab[TabSize-1] = 25'd1 << 24;
    return tab;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/log_return_mass_accumulator.sv
// A priced bar takes two passes through the shared logarithm unit (normalise, table
// read, interpolate), then the beta and decay products and the update; a series start or
// a bar with a zero price goes straight to the update. A new bar is taken only when the
// last is done, and a stalled result holds the bar in its update step.
// Reset clears all series state and loads the register defaults (decay one).
// ----------------------------------------------------------------------------
// Log-return mass accumulator
// Top level joining configuration, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module log_return_mass_accumulator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // price
  input  wire logic          s_axis_tuser,   // series_start
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // mass[31:0], is_active[32], run_count[48:33], newly_active[49],
  // direction[51:50], peak_level[83:52], active_bars[99:84], mass_total[131:100]
  output logic [135:0]       m_axis_tdata,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lrma_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lrma_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  lrma_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd)
  );

  lrma_dp u_dp (
    .clk_i, .rst_ni,
    .price_i(s_axis_tdata), .series_start_i(s_axis_tuser),
    .cfg_i(cfg), .cmd_i(cmd), .status_o(status), .result_o(m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lrma_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the accumulator settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lrma_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lrma_pkg::cfg_t    cfg_o
);
  import lrma_pkg::*;

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.critical_level     <= '0;
      cfg_q.form_threshold     <= '0;
      cfg_q.collapse_threshold <= '0;
      cfg_q.decay_factor       <= DecayOne;
      cfg_q.run_required       <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCritical: cfg_q.critical_level     <= pwdata;
        RegForm:     cfg_q.form_threshold     <= pwdata;
        RegCollapse: cfg_q.collapse_threshold <= pwdata;
        RegDecay:    cfg_q.decay_factor       <= pwdata[16:0];
        RegRunReq:   cfg_q.run_required       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCritical: prdata = cfg_q.critical_level;
      RegForm:     prdata = cfg_q.form_threshold;
      RegCollapse: prdata = cfg_q.collapse_threshold;
      RegDecay:    prdata = {15'd0, cfg_q.decay_factor};
      RegRunReq:   prdata = {16'd0, cfg_q.run_required};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lrma_ctrl.sv
// ----------------------------------------------------------------------------
// Accumulator controller
// Sequences the two logarithms, the beta and decay products and the update.
// ----------------------------------------------------------------------------
`default_nettype none

module lrma_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire lrma_pkg::status_t status_i,
  output lrma_pkg::cmd_t     cmd_o
);
  import lrma_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StNorm   = 7'b0000010,
    StRom    = 7'b0000100,
    StInterp = 7'b0001000,
    StBeta   = 7'b0010000,
    StDecay  = 7'b0100000,
    StUpdate = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   ovalid_q, ovalid_d;
  logic   accept, out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~ovalid_q | out_ready_i;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel_last = sel_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          sel_d   = 1'b0;
          state_d = status_i.skip ? StUpdate : StNorm;
        end
      end
      StNorm: begin
        cmd_o.norm = 1'b1;
        state_d = StRom;
      end
      StRom: begin
        cmd_o.rom_rd = 1'b1;
        state_d = StInterp;
      end
      StInterp: begin
        cmd_o.interp = 1'b1;
        sel_d   = 1'b1;
        state_d = sel_q ? StBeta : StNorm;
      end
      StBeta: begin
        cmd_o.beta = 1'b1;
        state_d = StDecay;
      end
      StDecay: begin
        cmd_o.decay = 1'b1;
        state_d = StUpdate;
      end
      StUpdate: begin
        if (out_free) begin
          cmd_o.update = 1'b1;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      sel_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lrma_dp.sv
// ----------------------------------------------------------------------------
// Accumulator datapath
// Logarithm unit, beta and decay products, series state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrma_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      price_i,
  input  wire logic             series_start_i,
  input  wire lrma_pkg::cfg_t   cfg_i,
  input  wire lrma_pkg::cmd_t   cmd_i,
  output lrma_pkg::status_t     status_o,
  output logic [135:0]          result_o
);
  import lrma_pkg::*;

  localparam log_tab_t LogTab = build_log_tab();

  logic [31:0] price_q, last_price_q;
  logic        init_q, zero_q, have_q;
  logic [4:0]  e_q, e_d;
  logic [LogTableBits-1:0] idx_q;
  logic [RemBits-1:0]      rem_q;
  logic [24:0] lo_q, hi_q;
  logic [31:0] lp_q, lq_q, beta_q;
  logic [32:0] dm_q;
  logic        timelike_q;
  logic [31:0] decayed_q;
  logic [31:0] mass_q, total_q, peak_q;
  logic        active_q;
  logic signed [1:0] dir_q;
  logic [15:0] run_q, bars_q;
  logic [135:0] result_q;

  logic [31:0] norm_x, norm_n;
  logic [TabIdxW-1:0] idx_lo, idx_hi;
  logic [24:0] diff;
  logic [45:0] interp_prod;
  logic [31:0] log_val, dlog;
  logic [63:0] beta_prod;
  logic [48:0] decay_prod;

  logic [31:0] mass_d, total_d, peak_d, last_d;
  logic        active_d, newly_d;
  logic signed [1:0] dir_d;
  logic [15:0] run_d, bars_d;
  logic [33:0] mass_sum, total_sum;

  assign status_o.skip = series_start_i | ~have_q | (price_i == '0) | (last_price_q == '0);

  always_comb begin
    norm_x = cmd_i.sel_last ? last_price_q : price_q;
    e_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (norm_x[b]) e_d = 5'(b);
    end
    norm_n = norm_x << (5'd31 - e_d);
  end

  assign idx_lo      = {1'b0, idx_q};
  assign idx_hi      = idx_lo + 1'b1;
  assign diff        = hi_q - lo_q;
  assign interp_prod = 46'(diff) * 46'(rem_q);
  assign log_val     = {3'd0, e_q, 24'd0} + {7'd0, lo_q} + 32'(interp_prod >> RemBits);
  assign dlog        = (lp_q >= lq_q) ? lp_q - lq_q : lq_q - lp_q;
  assign beta_prod   = 64'(dlog) * 64'(Ln2Q32) + 64'h8000_0000;
  assign decay_prod  = 49'(mass_q) * 49'(cfg_i.decay_factor);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      price_q <= price_i;
      init_q  <= series_start_i | ~have_q;
      zero_q  <= (price_i == '0) | (last_price_q == '0);
    end
    if (cmd_i.norm) begin
      e_q   <= e_d;
      idx_q <= norm_n[30:RemBits];
      rem_q <= norm_n[RemBits-1:0];
    end
    if (cmd_i.rom_rd) begin
      lo_q <= LogTab[idx_lo];
      hi_q <= LogTab[idx_hi];
    end
    if (cmd_i.interp) begin
      if (cmd_i.sel_last) lq_q <= log_val;
      else                lp_q <= log_val;
    end
    if (cmd_i.beta) begin
      beta_q <= beta_prod[63:32];
    end
    if (cmd_i.decay) begin
      timelike_q <= beta_q < cfg_i.critical_level;
      dm_q <= (beta_q < cfg_i.critical_level) ? {2'd0, cfg_i.critical_level[31:1]}
                                               : {beta_q - cfg_i.critical_level, 1'b0};
      decayed_q <= (decay_prod[48:16] > {1'b0, Sat32}) ? Sat32 : decay_prod[47:16];
    end
    if (cmd_i.update) begin
      result_q <= {4'd0, total_d, bars_d, peak_d, dir_d, newly_d, run_d, active_d, mass_d};
    end
  end

  assign mass_sum  = {2'd0, decayed_q} + {1'b0, dm_q};
  assign total_sum = {2'd0, total_q} + {1'b0, dm_q};

  always_comb begin
    mass_d   = mass_q;
    total_d  = total_q;
    peak_d   = peak_q;
    last_d   = last_price_q;
    active_d = active_q;
    dir_d    = dir_q;
    run_d    = run_q;
    bars_d   = bars_q;
    newly_d  = 1'b0;
    priority if (init_q) begin
      mass_d = '0; total_d = '0; peak_d = '0; active_d = 1'b0;
      dir_d = DirNone; run_d = '0; bars_d = '0;
      last_d = price_q;
    end else if (zero_q) begin
      newly_d = 1'b0;
    end else begin
      mass_d  = (mass_sum > {2'd0, Sat32}) ? Sat32 : mass_sum[31:0];
      total_d = (total_sum > {2'd0, Sat32}) ? Sat32 : total_sum[31:0];
      run_d   = timelike_q ? ((run_q == Sat16) ? Sat16 : run_q + 16'd1) : '0;
      if (price_q > last_price_q) dir_d = DirUp;
      else if (price_q < last_price_q) dir_d = DirDown;
      if (!active_q) begin
        if (mass_d >= cfg_i.form_threshold && run_d >= cfg_i.run_required) begin
          active_d = 1'b1;
          bars_d   = '0;
          peak_d   = mass_d;
          newly_d  = 1'b1;
        end
      end else begin
        bars_d = (bars_q == Sat16) ? Sat16 : bars_q + 16'd1;
        if (mass_d > peak_q) peak_d = mass_d;
        if (mass_d < cfg_i.collapse_threshold) begin
          active_d = 1'b0;
          mass_d = '0; run_d = '0; dir_d = DirNone; peak_d = '0; bars_d = '0;
        end
      end
      last_d = price_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_price_q <= '0;
      have_q       <= 1'b0;
      mass_q       <= '0;
      total_q      <= '0;
      peak_q       <= '0;
      active_q     <= 1'b0;
      dir_q        <= DirNone;
      run_q        <= '0;
      bars_q       <= '0;
    end else if (cmd_i.update) begin
      last_price_q <= last_d;
      have_q       <= 1'b1;
      mass_q       <= mass_d;
      total_q      <= total_d;
      peak_q       <= peak_d;
      active_q     <= active_d;
      dir_q        <= dir_d;
      run_q        <= run_d;
      bars_q       <= bars_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

>>> hw/rtl/lrma_chk.sv
// ----------------------------------------------------------------------------
// Accumulator port checker
// Checks output transactions seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lrma_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [135:0] m_axis_tdata
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("tvalid dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("tdata changed");

  a_newly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[49] |-> m_axis_tdata[32])
    else $error("activation without active state");

  a_idle_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[83:52] == '0 &&
    m_axis_tdata[99:84] == '0) else $error("inactive result with peak or bars");

  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[51:50] != 2'b10) else $error("bad direction code");

endmodule

bind log_return_mass_accumulator lrma_chk u_lrma_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

`default_nettype wire
